>>> rtl/tfrp_pkg.sv
// Package for the TDC and flash ADC readout parser.
// Holds sizes, codes, the item and divider types and small helper functions.
// No dependencies.
`timescale 1ns / 1ps

package tfrp_pkg;

   localparam int ADC_BOARDS     = 2;
   localparam int ADC_CHANNELS   = 8;
   localparam int MAX_SAMPLES    = 1024;
   localparam int MAX_HITS       = 64;
   localparam int TDC_CHIP_COUNT = 4;

   localparam int BRD_W     = $clog2(ADC_BOARDS + 1);
   localparam int HIT_W     = $clog2(MAX_HITS + 1);
   localparam int DWL_W     = 28;
   localparam int NUM_W     = DWL_W + 1;
   localparam int SPC_W     = 11;
   localparam int DIV_CNT_W = $clog2(NUM_W);

   localparam logic [4:0] T_GHDR = 5'h08;
   localparam logic [4:0] T_CHDR = 5'h01;
   localparam logic [4:0] T_MEAS = 5'h00;
   localparam logic [4:0] T_CTRL = 5'h03;
   localparam logic [4:0] T_ERR  = 5'h04;
   localparam logic [4:0] T_TTAG = 5'h11;
   localparam logic [4:0] T_GTRL = 5'h10;
   localparam logic [3:0] ADC_HEAD_NIBBLE = 4'hA;

   localparam logic [3:0] ERR_FIRST     = 4'd0;
   localparam logic [3:0] ERR_CHIP      = 4'd1;
   localparam logic [3:0] ERR_CHIP_CNT  = 4'd2;
   localparam logic [3:0] ERR_GLOB_CNT  = 4'd3;
   localparam logic [3:0] ERR_SMP_CHG   = 4'd4;
   localparam logic [3:0] ERR_NO_CHAN   = 4'd5;
   localparam logic [3:0] ERR_HIT_OVF   = 4'd6;
   localparam logic [3:0] ERR_SMP_OVF   = 4'd7;
   localparam logic [3:0] ERR_TRUNC     = 4'd8;

   typedef enum logic [1:0] {
      KIND_HIT   = 2'd0,
      KIND_PAIR  = 2'd1,
      KIND_ERROR = 2'd2,
      KIND_EMPTY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_FIRST,
      PH_TDC,
      PH_AHEAD,
      PH_ADATA,
      PH_DIV
   } phase_type;

   typedef enum logic [2:0] {
      WC_GHDR,
      WC_CHDR,
      WC_MEAS,
      WC_CTRL,
      WC_ERR,
      WC_TTAG,
      WC_GTRL,
      WC_OTHER
   } wclass_type;

   typedef struct packed {
      logic [31:0] word;
      logic        start;
      logic        adc_head;
      wclass_type  wclass;
   } item_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [3:0]       den;
   } div_ctl_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_sts_type;

   function automatic logic [2:0] lowest_bit(input logic [7:0] m);
      logic [2:0] r;
      r = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (m[i]) r = 3'(i);
      end
      return r;
   endfunction

   function automatic logic [3:0] pop_count(input logic [7:0] m);
      logic [3:0] r;
      r = 4'd0;
      for (int i = 0; i < 8; i++) begin
         r = r + 4'(m[i]);
      end
      return r;
   endfunction

endpackage

>>> rtl/tfrp_front.sv
// Front part of the readout parser: classifies each incoming word by type.
// Depends on tfrp_pkg.
`timescale 1ns / 1ps

module tfrp_front (
   input  logic              req_valid,
   input  logic [31:0]       req_word,
   input  logic              req_event_start,
   input  logic              q_full,
   output logic              req_ready,
   output logic              q_push,
   output tfrp_pkg::item_type q_item
);
   import tfrp_pkg::*;

   logic [4:0] wtype;

   assign wtype     = req_word[31:27];
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.word     = req_word;
      q_item.start    = req_event_start;
      q_item.adc_head = (req_word[31:28] == ADC_HEAD_NIBBLE);
      case (wtype)
         T_GHDR:  q_item.wclass = WC_GHDR;
         T_CHDR:  q_item.wclass = WC_CHDR;
         T_MEAS:  q_item.wclass = WC_MEAS;
         T_CTRL:  q_item.wclass = WC_CTRL;
         T_ERR:   q_item.wclass = WC_ERR;
         T_TTAG:  q_item.wclass = WC_TTAG;
         T_GTRL:  q_item.wclass = WC_GTRL;
         default: q_item.wclass = WC_OTHER;
      endcase
   end

endmodule

>>> rtl/tfrp_queue.sv
// Two-entry queue of classified items between the front and back parts.
// Depends on tfrp_pkg.
`timescale 1ns / 1ps

module tfrp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tfrp_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               valid,
   output tfrp_pkg::item_type head
);
   import tfrp_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

endmodule

>>> rtl/tfrp_div.sv
// Bit-serial restoring divider for samples per channel, one quotient bit a cycle.
// Depends on tfrp_pkg.
`timescale 1ns / 1ps

module tfrp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tfrp_pkg::div_ctl_type ctl,
   output tfrp_pkg::div_sts_type sts
);
   import tfrp_pkg::*;

   logic [NUM_W-1:0]     num_ff, num_in;
   logic [2:0]           rem_ff, rem_in;
   logic [3:0]           den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [3:0]           trial;

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.quot = num_ff;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (ctl.start) begin
         num_in  = ctl.num;
         rem_in  = 3'd0;
         den_in  = ctl.den;
         cnt_in  = DIV_CNT_W'(NUM_W - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= den_ff) begin
            rem_in = 3'(trial - den_ff);
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[2:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

endmodule

>>> rtl/tfrp_back.sv
// Back part of the readout parser: event state machine and registered result.
// Depends on tfrp_pkg; drives the divider through div_ctl_type.
`timescale 1ns / 1ps

module tfrp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  tfrp_pkg::item_type    q_item,
   output logic                  q_pop,
   output tfrp_pkg::div_ctl_type div_ctl,
   input  tfrp_pkg::div_sts_type div_sts,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [4:0]            rsp_channel,
   output logic [9:0]            rsp_index,
   output logic signed [21:0]    rsp_value_first,
   output logic signed [12:0]    rsp_value_second,
   output logic [3:0]            rsp_error_code,
   output logic                  rsp_event_done
);
   import tfrp_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [1:0]       hp_ff, hp_in;
   logic [15:0]      total_ff, total_in;
   logic [11:0]      chip_ff [4];
   logic [11:0]      chip_in [4];
   logic [1:0]       open_ff, open_in;
   logic [HIT_W-1:0] hit_ff, hit_in;
   logic [BRD_W-1:0] board_ff, board_in;
   logic [DWL_W-1:0] dwl_ff, dwl_in;
   logic [7:0]       mask_ff, mask_in;
   logic [2:0]       cur_ff, cur_in;
   logic [9:0]       pair_ff, pair_in;
   logic [SPC_W-1:0] spc_ff, spc_in;
   logic [SPC_W-1:0] prev_ff, prev_in;
   logic             prev_valid_ff, prev_valid_in;

   logic             out_valid_ff, out_valid_in;
   kind_type         kind_ff, kind_in;
   logic [4:0]       chan_ff, chan_in;
   logic [9:0]       idx_ff, idx_in;
   logic [21:0]      v1_ff, v1_in;
   logic [12:0]      v2_ff, v2_in;
   logic [3:0]       code_ff, code_in;
   logic             done_ff, done_in;

   logic             slot_free;
   logic             emit;
   logic [31:0]      w;
   logic [27:0]      size;
   logic [3:0]       act;
   logic [NUM_W-1:0] spc;
   logic [15:0]      tot_inc;
   logic [11:0]      cnt_inc;
   logic [DWL_W-1:0] dwl_dec;
   logic [BRD_W-1:0] board_inc;
   logic [12:0]      s1;
   logic [12:0]      s2;
   logic [7:0]       ch_full;
   logic [SPC_W-1:0] pair_inc;

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_channel      = chan_ff;
   assign rsp_index        = idx_ff;
   assign rsp_value_first  = v1_ff;
   assign rsp_value_second = v2_ff;
   assign rsp_error_code   = code_ff;
   assign rsp_event_done   = done_ff;

   assign slot_free = !out_valid_ff || rsp_ready;

   always_comb begin
      phase_in      = phase_ff;
      hp_in         = hp_ff;
      total_in      = total_ff;
      chip_in       = chip_ff;
      open_in       = open_ff;
      hit_in        = hit_ff;
      board_in      = board_ff;
      dwl_in        = dwl_ff;
      mask_in       = mask_ff;
      cur_in        = cur_ff;
      pair_in       = pair_ff;
      spc_in        = spc_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      emit          = 1'b0;
      kind_in       = KIND_ERROR;
      chan_in       = 5'd0;
      idx_in        = 10'd0;
      v1_in         = 22'd0;
      v2_in         = 13'd0;
      code_in       = 4'd0;
      done_in       = 1'b0;
      q_pop         = 1'b0;
      div_ctl.start = 1'b0;
      div_ctl.num   = {dwl_ff, 1'b0};
      div_ctl.den   = 4'd0;
      w             = q_item.word;
      size          = w[27:0];
      act           = pop_count(w[7:0]);
      spc           = div_sts.quot;
      tot_inc       = total_ff + 16'd1;
      cnt_inc       = chip_ff[open_ff] + 12'd1;
      dwl_dec       = dwl_ff - 1'b1;
      board_inc     = board_ff + 1'b1;
      s1            = {1'b0, w[11:0]} - 13'h0FFF;
      s2            = {1'b0, w[27:16]} - 13'h0FFF;
      ch_full       = 8'({board_ff, cur_ff});
      pair_inc      = {1'b0, pair_ff} + 11'd1;

      if (phase_ff == PH_DIV) begin
         if (div_sts.done && slot_free) begin
            if (dwl_ff != '0 && (spc < NUM_W'(2) || spc > NUM_W'(MAX_SAMPLES))) begin
               emit = 1'b1; code_in = ERR_SMP_OVF; done_in = 1'b1; phase_in = PH_IDLE;
            end else if (prev_valid_ff && spc != NUM_W'(prev_ff)) begin
               emit = 1'b1; code_in = ERR_SMP_CHG; done_in = 1'b1; phase_in = PH_IDLE;
            end else begin
               spc_in        = spc[SPC_W-1:0];
               prev_in       = spc[SPC_W-1:0];
               prev_valid_in = 1'b1;
               cur_in        = lowest_bit(mask_ff);
               pair_in       = 10'd0;
               hp_in         = 2'd2;
               phase_in      = PH_AHEAD;
            end
         end
      end else if (q_valid && slot_free) begin
         q_pop = 1'b1;
         if (q_item.start) begin
            if (phase_ff != PH_IDLE) begin
               emit = 1'b1; code_in = ERR_TRUNC; done_in = 1'b1;
            end
            phase_in = PH_LEAD;
         end else begin
            case (phase_ff)
               PH_LEAD: phase_in = PH_FIRST;
               PH_FIRST: begin
                  if (q_item.wclass != WC_GHDR) begin
                     emit = 1'b1; code_in = ERR_FIRST; done_in = 1'b1; phase_in = PH_IDLE;
                  end else begin
                     for (int i = 0; i < 4; i++) chip_in[i] = 12'd0;
                     open_in  = 2'd0;
                     hit_in   = '0;
                     total_in = 16'd1;
                     phase_in = PH_TDC;
                  end
               end
               PH_TDC: begin
                  if (q_item.adc_head) begin
                     board_in = '0;
                     dwl_in   = (size >= 28'd4) ? size - 28'd4 : '0;
                     hp_in    = 2'd1;
                     phase_in = PH_AHEAD;
                  end else begin
                     case (q_item.wclass)
                        WC_GHDR, WC_ERR, WC_TTAG: total_in = tot_inc;
                        WC_CHDR: begin
                           if ({1'b0, w[25:24]} >= 3'(TDC_CHIP_COUNT)) begin
                              emit = 1'b1; code_in = ERR_CHIP; done_in = 1'b1;
                              phase_in = PH_IDLE;
                           end else begin
                              open_in            = w[25:24];
                              chip_in[w[25:24]]  = 12'd1;
                              total_in           = tot_inc;
                           end
                        end
                        WC_MEAS: begin
                           if (hit_ff >= HIT_W'(MAX_HITS)) begin
                              emit = 1'b1; code_in = ERR_HIT_OVF; done_in = 1'b1;
                              phase_in = PH_IDLE;
                           end else begin
                              chip_in[open_ff] = cnt_inc;
                              total_in         = tot_inc;
                              hit_in           = hit_ff + 1'b1;
                              emit             = 1'b1;
                              kind_in          = KIND_HIT;
                              chan_in          = w[25:21];
                              idx_in           = 10'(hit_ff);
                              v1_in            = {1'b0, w[20:0]};
                           end
                        end
                        WC_CTRL: begin
                           if (open_ff != w[25:24]) begin
                              emit = 1'b1; code_in = ERR_CHIP; done_in = 1'b1;
                              phase_in = PH_IDLE;
                           end else begin
                              chip_in[open_ff] = cnt_inc;
                              total_in         = tot_inc;
                              if (cnt_inc != w[11:0]) begin
                                 emit = 1'b1; code_in = ERR_CHIP_CNT; done_in = 1'b1;
                                 phase_in = PH_IDLE;
                              end
                           end
                        end
                        WC_GTRL: begin
                           total_in = tot_inc;
                           if (tot_inc != w[20:5]) begin
                              emit = 1'b1; code_in = ERR_GLOB_CNT; done_in = 1'b1;
                              phase_in = PH_IDLE;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
               PH_AHEAD: begin
                  case (hp_ff)
                     2'd0: begin
                        dwl_in = (size >= 28'd4) ? size - 28'd4 : '0;
                        hp_in  = 2'd1;
                     end
                     2'd1: begin
                        if (act == 4'd0) begin
                           emit = 1'b1; code_in = ERR_NO_CHAN; done_in = 1'b1;
                           phase_in = PH_IDLE;
                        end else begin
                           mask_in       = w[7:0];
                           div_ctl.start = 1'b1;
                           div_ctl.den   = act;
                           phase_in      = PH_DIV;
                        end
                     end
                     2'd2: hp_in = 2'd3;
                     default: begin
                        if (dwl_ff == '0) begin
                           board_in = board_inc;
                           if (board_inc >= BRD_W'(ADC_BOARDS)) begin
                              phase_in = PH_IDLE;
                              emit     = 1'b1;
                              kind_in  = KIND_EMPTY;
                              done_in  = 1'b1;
                           end else begin
                              phase_in = PH_AHEAD;
                              hp_in    = 2'd0;
                           end
                        end else begin
                           phase_in = PH_ADATA;
                           pair_in  = 10'd0;
                        end
                     end
                  endcase
               end
               PH_ADATA: begin
                  dwl_in = dwl_dec;
                  if (mask_ff != 8'd0) begin
                     emit    = 1'b1;
                     kind_in = KIND_PAIR;
                     chan_in = ch_full[4:0];
                     idx_in  = {pair_ff[8:0], 1'b0};
                     v1_in   = {{9{s1[12]}}, s1};
                     v2_in   = s2;
                     if (pair_inc >= SPC_W'(spc_ff[SPC_W-1:1])) begin
                        mask_in = mask_ff & ~(8'd1 << cur_ff);
                        pair_in = 10'd0;
                        cur_in  = lowest_bit(mask_ff & ~(8'd1 << cur_ff));
                     end else begin
                        pair_in = pair_inc[9:0];
                     end
                  end
                  if (dwl_dec == '0) begin
                     board_in = board_inc;
                     if (board_inc >= BRD_W'(ADC_BOARDS)) begin
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                        if (mask_ff == 8'd0) begin
                           emit    = 1'b1;
                           kind_in = KIND_EMPTY;
                        end
                     end else begin
                        phase_in = PH_AHEAD;
                        hp_in    = 2'd0;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
      out_valid_in = slot_free ? emit : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hp_ff         <= 2'd0;
         total_ff      <= 16'd0;
         for (int i = 0; i < 4; i++) chip_ff[i] <= 12'd0;
         open_ff       <= 2'd0;
         hit_ff        <= '0;
         board_ff      <= '0;
         dwl_ff        <= '0;
         mask_ff       <= 8'd0;
         cur_ff        <= 3'd0;
         pair_ff       <= 10'd0;
         spc_ff        <= '0;
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         hp_ff         <= hp_in;
         total_ff      <= total_in;
         chip_ff       <= chip_in;
         open_ff       <= open_in;
         hit_ff        <= hit_in;
         board_ff      <= board_in;
         dwl_ff        <= dwl_in;
         mask_ff       <= mask_in;
         cur_ff        <= cur_in;
         pair_ff       <= pair_in;
         spc_ff        <= spc_in;
         prev_ff       <= prev_in;
         prev_valid_ff <= prev_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && slot_free) begin
         kind_ff <= kind_in;
         chan_ff <= chan_in;
         idx_ff  <= idx_in;
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         code_ff <= code_in;
         done_ff <= done_in;
      end
   end

endmodule

>>> rtl/tdc_fadc_readout_parser_unit.sv
// Top level of the TDC and flash ADC readout parser.
// Depends on tfrp_pkg, tfrp_front, tfrp_queue, tfrp_div and tfrp_back.
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_ready   word, event_start
//   rsp_      out         rsp_valid / rsp_ready   kind, channel, index, values, code, done
//
// One word is taken per cycle while req_ready is high; a board channel-mask header word
// starts the bit-serial samples-per-channel divider, during which the back part holds.
// Results leave through a registered output; a word passes the queue register, then the output register.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A stalled result stops the back part, the two-entry queue fills, then req_ready drops.
`timescale 1ns / 1ps

module tdc_fadc_readout_parser_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_word,
   input  logic               req_event_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [4:0]         rsp_channel,
   output logic [9:0]         rsp_index,
   output logic signed [21:0] rsp_value_first,
   output logic signed [12:0] rsp_value_second,
   output logic [3:0]         rsp_error_code,
   output logic               rsp_event_done
);
   import tfrp_pkg::*;

   item_type    push_item;
   item_type    head_item;
   logic        q_push;
   logic        q_full;
   logic        q_valid;
   logic        q_pop;
   div_ctl_type div_ctl;
   div_sts_type div_sts;

   tfrp_front u_front (
      .req_valid       (req_valid),
      .req_word        (req_word),
      .req_event_start (req_event_start),
      .q_full          (q_full),
      .req_ready       (req_ready),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   tfrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .head      (head_item)
   );

   tfrp_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   tfrp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (head_item),
      .q_pop            (q_pop),
      .div_ctl          (div_ctl),
      .div_sts          (div_sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_channel      (rsp_channel),
      .rsp_index        (rsp_index),
      .rsp_value_first  (rsp_value_first),
      .rsp_value_second (rsp_value_second),
      .rsp_error_code   (rsp_error_code),
      .rsp_event_done   (rsp_event_done)
   );

`ifndef SYNTHESIS
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("Item taken from an empty queue.");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_sts.busy)
      else $error("Divider restarted while busy.");

   a_div_clear: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |=> (div_sts.busy && !div_sts.done))
      else $error("Divider did not start after a request.");
`endif

endmodule
